// ===== src/salc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

   localparam int ADDR_W     = 32;
   localparam int OFFSET_W   = 4;
   localparam int INDEX_W    = 3;
   localparam int RANK_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   // widest set-select value that index_bits can produce
   localparam int SEL_W     = (1 << INDEX_W) - 1;
   localparam int LUT_DEPTH = 1 << SEL_W;

   // response tdata: hit, hit_rank, evicted, then zero padding to a byte
   localparam int RSP_FIELDS_W = 1 + RANK_W + 1;
   localparam int RSP_W        = 8;
   localparam int RSP_PAD_W    = RSP_W - RSP_FIELDS_W;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(5);
   localparam logic [INDEX_W-1:0]  INDEX_RESET  = INDEX_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 1'b0,
      CSR_INDEX_BITS  = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// ===== src/salc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_queue #(
   parameter int WIDTH = 38
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/salc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_front #(
   parameter int MAX_SETS = 64,
   parameter int SET_W    = 6
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [salc_pkg::ADDR_W-1:0]       req_tdata,
   input  wire logic                              csr_wen,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [salc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              clearing,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output logic      [salc_pkg::ADDR_W-1:0]       push_block,
   output logic      [SET_W-1:0]                  push_set
);

   import salc_pkg::*;

   logic [OFFSET_W-1:0] offset_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [SEL_W-1:0]    sel_mask;
   logic [SEL_W-1:0]    sel;
   logic [SET_W-1:0]    set_lut [LUT_DEPTH];

   // set number wraps modulo the sets that are built
   for (genvar i = 0; i < LUT_DEPTH; i++) begin : g_lut
      assign set_lut[i] = SET_W'(i % MAX_SETS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         index_ff  <= INDEX_RESET;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_OFFSET_BITS: offset_ff <= csr_wdata;
            CSR_INDEX_BITS:  index_ff  <= csr_wdata[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sel_mask   = SEL_W'((9'd1 << index_ff) - 9'd1);
      push_block = req_tdata >> offset_ff;
      sel        = push_block[SEL_W-1:0] & sel_mask;
      push_set   = set_lut[sel];
   end

   assign push_valid = req_tvalid && !clearing;
   assign req_tready = push_ready && !clearing;

endmodule

`default_nettype wire

// ===== src/salc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_back #(
   parameter int WAYS     = 8,
   parameter int MAX_SETS = 64,
   parameter int SET_W    = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          pop_valid,
   output logic                               pop_ready,
   input  wire logic [salc_pkg::ADDR_W-1:0]   pop_block,
   input  wire logic [SET_W-1:0]              pop_set,
   output logic                               clearing,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [salc_pkg::RSP_W-1:0]    rsp_tdata
);

   import salc_pkg::*;

   localparam int WAY_W   = $clog2(WAYS);
   localparam int CNT_W   = $clog2(WAYS + 1);
   localparam int ROW_W   = WAYS * ADDR_W;
   localparam int ORDER_W = WAYS * WAY_W;
   localparam int META_W  = ORDER_W + CNT_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } state_type;

   // per set: tag row, and recency order (most recent first) with fill count
   logic [ROW_W-1:0]  tag_mem  [MAX_SETS];
   logic [META_W-1:0] meta_mem [MAX_SETS];

   state_type          state_ff;
   logic [SET_W-1:0]   clr_ptr_ff;
   logic [ROW_W-1:0]   tag_rd_ff;
   logic [META_W-1:0]  meta_rd_ff;
   logic [ADDR_W-1:0]  block_ff;
   logic [SET_W-1:0]   set_ff;
   logic               rsp_valid_ff;
   logic               hit_ff;
   logic [RANK_W-1:0]  rank_ff;
   logic               evicted_ff;

   logic [WAY_W-1:0]   order     [WAYS];
   logic [WAY_W-1:0]   order_in  [WAYS];
   logic [ADDR_W-1:0]  rank_tag  [WAYS];
   logic [WAYS-1:0]    match;
   logic [CNT_W-1:0]   count;
   logic [CNT_W-1:0]   count_in;
   logic               hit;
   logic [WAY_W-1:0]   hit_rank;
   logic [WAY_W-1:0]   move_rank;
   logic [WAY_W-1:0]   victim;
   logic               full;
   logic               evicted;
   logic [ROW_W-1:0]   row_in;
   logic [META_W-1:0]  meta_in;
   logic [META_W-1:0]  meta_reset;
   logic               pop;
   logic               update;

   assign pop_ready  = (state_ff == ST_IDLE);
   assign pop        = pop_ready && pop_valid;
   assign update     = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_tready);
   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), evicted_ff, rank_ff, hit_ff};

   always_comb begin
      for (int r = 0; r < WAYS; r++) begin
         order[r] = meta_rd_ff[r*WAY_W +: WAY_W];
      end
      count = meta_rd_ff[ORDER_W +: CNT_W];

      // tag of the way at each rank; ranks past the fill count are empty
      for (int r = 0; r < WAYS; r++) begin
         rank_tag[r] = '0;
         for (int w = 0; w < WAYS; w++) begin
            if (order[r] == WAY_W'(w)) begin
               rank_tag[r] = tag_rd_ff[w*ADDR_W +: ADDR_W];
            end
         end
         match[r] = (CNT_W'(r) < count) && (rank_tag[r] == block_ff);
      end

      hit      = 1'b0;
      hit_rank = '0;
      for (int r = WAYS - 1; r >= 0; r--) begin
         if (match[r]) begin
            hit      = 1'b1;
            hit_rank = WAY_W'(r);
         end
      end

      move_rank = hit ? hit_rank : WAY_W'(WAYS - 1);
      victim    = order[WAYS-1];
      full      = (count == CNT_W'(WAYS));
      evicted   = !hit && full;
      count_in  = (hit || full) ? count : count + 1'b1;

      order_in[0] = order[move_rank];
      for (int r = 1; r < WAYS; r++) begin
         order_in[r] = (WAY_W'(r) <= move_rank) ? order[r-1] : order[r];
      end

      for (int w = 0; w < WAYS; w++) begin
         row_in[w*ADDR_W +: ADDR_W] = (!hit && victim == WAY_W'(w)) ?
                                      block_ff : tag_rd_ff[w*ADDR_W +: ADDR_W];
      end

      for (int r = 0; r < WAYS; r++) begin
         meta_in[r*WAY_W +: WAY_W]    = order_in[r];
         meta_reset[r*WAY_W +: WAY_W] = WAY_W'(r);
      end
      meta_in[ORDER_W +: CNT_W]    = count_in;
      meta_reset[ORDER_W +: CNT_W] = '0;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         meta_mem[clr_ptr_ff] <= meta_reset;
      end else if (update) begin
         meta_mem[set_ff] <= meta_in;
      end
      if (pop) begin
         meta_rd_ff <= meta_mem[pop_set];
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         tag_mem[set_ff] <= row_in;
      end
      if (pop) begin
         tag_rd_ff <= tag_mem[pop_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !update) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ptr_ff <= clr_ptr_ff + 1'b1;
               if (clr_ptr_ff == SET_W'(MAX_SETS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (pop_valid) begin
                  block_ff <= pop_block;
                  set_ff   <= pop_set;
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               if (update) begin
                  rsp_valid_ff <= 1'b1;
                  hit_ff       <= hit;
                  rank_ff      <= RANK_W'(hit_rank);
                  evicted_ff   <= evicted;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/set_assoc_lru_cache_tags.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tag store of a WAYS-way set-associative cache with true LRU replacement.
// Each request carries a 32-bit byte address; the front splits it with the
// configured offset_bits and index_bits into block number and set, and a
// two-entry queue hands it to the lookup engine. The engine reads the set's
// tag row and recency row from block memories into registers when it takes
// a request, then compares, reorders and writes back once any earlier
// response has been taken; it takes no new request until then. The response
// holds hit, the hit way's recency rank before the update (0 most recent)
// and whether a miss evicted a valid tag. After reset the recency memory is
// swept set by set, during which no request is taken; csr writes are taken
// at any time but should only be made while the block is idle.
// Set numbers at or above MAX_SETS wrap modulo MAX_SETS.
module set_assoc_lru_cache_tags #(
   parameter int WAYS     = 8,
   parameter int MAX_SETS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [31:0] address
   input  wire logic [salc_pkg::ADDR_W-1:0]       req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] hit, [3:1] hit_rank, [4] evicted, [7:5] zero
   output logic      [salc_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                              csr_wen,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [salc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import salc_pkg::*;

   localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int ENTRY_W = ADDR_W + SET_W;

   logic               clearing;
   logic               push_valid, push_ready;
   logic [ADDR_W-1:0]  push_block;
   logic [SET_W-1:0]   push_set;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   salc_front #(
      .MAX_SETS (MAX_SETS),
      .SET_W    (SET_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_block (push_block),
      .push_set   (push_set)
   );

   salc_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_set, push_block}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   salc_back #(
      .WAYS     (WAYS),
      .MAX_SETS (MAX_SETS),
      .SET_W    (SET_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_block  (pop_data[ADDR_W-1:0]),
      .pop_set    (pop_data[ENTRY_W-1:ADDR_W]),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
